@@ sv/cvu_pkg.sv @@
// Shared types, widths, mode codes and helpers for the cost volume update block.
// No dependencies; every other file imports this package.
`default_nettype none
package cvu_pkg;

  localparam int PIXELS_DEF = 4096;
  localparam int LAYERS_DEF = 32;

  localparam int PIX_W  = 12;
  localparam int LAY_W  = 5;
  localparam int CH_W   = 16;
  localparam int COST_W = 32;
  localparam int HITS_W = 16;
  localparam int SAD_W  = 18;
  localparam int SQ_W   = 32;
  localparam int L2_W   = 35;
  localparam int PROD_W = 48;
  // cost*(h-1) + (sad << 8)
  localparam int NUM_W  = 49;
  localparam int ADDR_W = 3;

  localparam logic [1:0] MODE_L1       = 2'd0;
  localparam logic [1:0] MODE_L2_COLOR = 2'd1;
  localparam logic [1:0] MODE_L2_GRAY  = 2'd2;

  // register word index (paddr[2])
  localparam logic REG_NORM_MODE = 1'b0;

  localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // result carried alongside the divider
  typedef struct packed {
    logic [COST_W-1:0] res_cost;
    logic [HITS_W-1:0] res_hits;
    logic              use_quot;
    logic              upd;
  } div_side_t;

  function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    absdiff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage
`default_nettype wire

@@ sv/cvu_cell_store.sv @@
// Cost and hit memories for all cells, with a zero-fill sweep after reset.
// Depends on cvu_pkg.
`default_nettype none
module cvu_cell_store #(
  parameter int CELLS  = 131072,
  parameter int CELL_W = 17
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rd_en,
  input  wire logic [CELL_W-1:0]          rd_addr,
  output logic [cvu_pkg::COST_W-1:0]      rd_cost,
  output logic [cvu_pkg::HITS_W-1:0]      rd_hits,
  input  wire logic                       wr_en,
  input  wire logic [CELL_W-1:0]          wr_addr,
  input  wire logic [cvu_pkg::COST_W-1:0] wr_cost,
  input  wire logic [cvu_pkg::HITS_W-1:0] wr_hits,
  output logic                            busy
);
  import cvu_pkg::*;

  logic [COST_W-1:0] cost_mem [CELLS];
  logic [HITS_W-1:0] hit_mem  [CELLS];
  logic [CELL_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == CELL_W'(CELLS - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      cost_mem[clr_addr] <= '0;
      hit_mem[clr_addr]  <= '0;
    end else if (wr_en) begin
      cost_mem[wr_addr] <= wr_cost;
      hit_mem[wr_addr]  <= wr_hits;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_cost <= cost_mem[rd_addr];
      rd_hits <= hit_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ sv/cvu_div_pipe.sv @@
// Restoring divider, one quotient bit per stage, carrying cell address and result.
// Depends on cvu_pkg.
`default_nettype none
module cvu_div_pipe #(
  parameter int CELL_W = 17
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       adv,
  input  wire logic                       in_vld,
  input  wire logic [cvu_pkg::NUM_W-1:0]  in_num,
  input  wire logic [cvu_pkg::HITS_W-1:0] in_den,
  input  wire cvu_pkg::div_side_t         in_side,
  input  wire logic [CELL_W-1:0]          in_addr,
  input  wire logic [CELL_W-1:0]          probe_addr,
  output logic                            probe_hit,
  output logic                            out_vld,
  output logic [cvu_pkg::NUM_W-1:0]       out_quot,
  output cvu_pkg::div_side_t              out_side,
  output logic [CELL_W-1:0]               out_addr
);
  import cvu_pkg::*;

  localparam int STAGES = NUM_W;

  logic              vld  [STAGES+1];
  logic [NUM_W-1:0]  word [STAGES+1];
  logic [HITS_W-1:0] rem  [STAGES+1];
  logic [HITS_W-1:0] den  [STAGES+1];
  div_side_t         side [STAGES+1];
  logic [CELL_W-1:0] addr [STAGES+1];

  assign vld[0]  = in_vld;
  assign word[0] = in_num;
  assign rem[0]  = '0;
  assign den[0]  = in_den;
  assign side[0] = in_side;
  assign addr[0] = in_addr;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam int B = NUM_W - 1 - i;
    logic [HITS_W:0]   trial;
    logic              ge;
    logic [HITS_W-1:0] rem_next;
    logic [NUM_W-1:0]  word_next;

    always_comb begin
      trial     = {rem[i], word[i][B]};
      ge        = trial >= {1'b0, den[i]};
      rem_next  = ge ? HITS_W'(trial - {1'b0, den[i]}) : trial[HITS_W-1:0];
      word_next = word[i];
      word_next[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        word[i+1] <= word_next;
        rem[i+1]  <= rem_next;
        den[i+1]  <= den[i];
        side[i+1] <= side[i];
        addr[i+1] <= addr[i];
      end
    end
  end

  always_comb begin
    probe_hit = 1'b0;
    for (int i = 1; i <= STAGES; i++) begin
      if (vld[i] && (addr[i] == probe_addr)) begin
        probe_hit = 1'b1;
      end
    end
  end

  assign out_vld  = vld[STAGES];
  assign out_quot = word[STAGES];
  assign out_side = side[STAGES];
  assign out_addr = addr[STAGES];

endmodule
`default_nettype wire

@@ sv/cost_volume_update.sv @@
// Cost volume update: one item per cycle while out_ready keeps the output moving and no hazard holds entry.
// A new item waits while an older one for the same cell is still in flight
// (read at entry, written back when its result leaves the divider).
// After reset all PIXELS*LAYERS cells of the memories are zero-filled; no item is
// accepted meanwhile. norm_mode resets to the L1 running average.
// Depends on cvu_pkg, cvu_cell_store, cvu_div_pipe.
`default_nettype none
module cost_volume_update #(
  parameter int PIXELS = cvu_pkg::PIXELS_DEF,
  parameter int LAYERS = cvu_pkg::LAYERS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cvu_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [cvu_pkg::PIX_W-1:0]   pixel_index,
  input  wire logic [cvu_pkg::LAY_W-1:0]   layer_index,
  input  wire logic                        visible,
  input  wire logic [cvu_pkg::CH_W-1:0]    warped_c0,
  input  wire logic [cvu_pkg::CH_W-1:0]    warped_c1,
  input  wire logic [cvu_pkg::CH_W-1:0]    warped_c2,
  input  wire logic [cvu_pkg::CH_W-1:0]    ref_c0,
  input  wire logic [cvu_pkg::CH_W-1:0]    ref_c1,
  input  wire logic [cvu_pkg::CH_W-1:0]    ref_c2,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [cvu_pkg::COST_W-1:0]       cell_cost,
  output logic [cvu_pkg::HITS_W-1:0]       cell_hits,
  output logic                             was_updated
);
  import cvu_pkg::*;

  localparam int CELLS  = PIXELS * LAYERS;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  // configuration
  logic [1:0] norm_mode;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NORM_MODE) ? {30'b0, norm_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_mode <= MODE_L1;
    end else if (psel && penable && pwrite && (paddr[2] == REG_NORM_MODE)) begin
      norm_mode <= pwdata[1:0];
    end
  end

  // entry
  logic              adv, accept, hazard, busy, div_hit;
  logic [31:0]       e_addr_full;
  logic [CELL_W-1:0] e_addr;
  logic              e_rng, e_upd;

  assign adv         = !out_valid || out_ready;
  assign e_addr_full = 32'(pixel_index) * 32'(LAYERS) + 32'(layer_index);
  assign e_addr      = e_addr_full[CELL_W-1:0];
  assign e_rng       = (32'(pixel_index) < 32'(PIXELS)) && (32'(layer_index) < 32'(LAYERS));
  assign e_upd       = visible && ((norm_mode == MODE_L1) || (norm_mode == MODE_L2_COLOR) ||
                                   (norm_mode == MODE_L2_GRAY));

  logic              a_vld, b_vld;
  logic [CELL_W-1:0] a_addr, b_addr;

  assign hazard   = (a_vld && (a_addr == e_addr)) || (b_vld && (b_addr == e_addr)) || div_hit;
  assign in_ready = adv && !busy && !hazard;
  assign accept   = in_valid && in_ready;

  // stage A: memory read returns
  logic [CH_W-1:0] a_d0, a_d1, a_d2;
  logic            a_rng, a_upd, a_m0, a_gray;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && accept) begin
      a_addr <= e_addr;
      a_d0   <= absdiff(warped_c0, ref_c0);
      a_d1   <= absdiff(warped_c1, ref_c1);
      a_d2   <= absdiff(warped_c2, ref_c2);
      a_rng  <= e_rng;
      a_upd  <= e_upd;
      a_m0   <= norm_mode == MODE_L1;
      a_gray <= norm_mode == MODE_L2_GRAY;
    end
  end

  logic [COST_W-1:0] rd_cost, wr_cost;
  logic [HITS_W-1:0] rd_hits, wr_hits;
  logic              wr_en;
  logic [CELL_W-1:0] wr_addr;

  cvu_cell_store #(
    .CELLS  (CELLS),
    .CELL_W (CELL_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (e_addr),
    .rd_cost (rd_cost),
    .rd_hits (rd_hits),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_cost (wr_cost),
    .wr_hits (wr_hits),
    .busy    (busy)
  );

  logic [HITS_W-1:0] a_nh;
  assign a_nh = (rd_hits == HITS_MAX) ? HITS_MAX : rd_hits + 1'b1;

  // stage B: products registered
  logic [PROD_W-1:0] b_prod;
  logic [SQ_W-1:0]   b_sq0, b_sq1, b_sq2;
  logic [SAD_W-1:0]  b_sad;
  logic [COST_W-1:0] b_cost;
  logic [HITS_W-1:0] b_hits, b_nh;
  logic              b_rng, b_upd, b_m0, b_gray;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_addr <= a_addr;
      b_prod <= PROD_W'(rd_cost) * PROD_W'(a_nh - 1'b1);
      b_sq0  <= SQ_W'(a_d0) * SQ_W'(a_d0);
      b_sq1  <= SQ_W'(a_d1) * SQ_W'(a_d1);
      b_sq2  <= SQ_W'(a_d2) * SQ_W'(a_d2);
      b_sad  <= SAD_W'(a_d0) + SAD_W'(a_d1) + SAD_W'(a_d2);
      b_cost <= rd_cost;
      b_hits <= rd_hits;
      b_nh   <= a_nh;
      b_rng  <= a_rng;
      b_upd  <= a_upd;
      b_m0   <= a_m0;
      b_gray <= a_gray;
    end
  end

  // numerator and L2 total, then hand off to the divider
  logic [NUM_W-1:0]  b_num;
  logic [L2_W-1:0]   b_l2;
  logic [COST_W-1:0] b_l2_sat;
  div_side_t         b_side;

  always_comb begin
    b_num    = {1'b0, b_prod} + {23'b0, b_sad, 8'b0};
    b_l2     = L2_W'(b_cost) + L2_W'(b_sq0);
    if (!b_gray) begin
      b_l2 = b_l2 + L2_W'(b_sq1) + L2_W'(b_sq2);
    end
    b_l2_sat = (|b_l2[L2_W-1:COST_W]) ? COST_MAX : b_l2[COST_W-1:0];
    if (!b_rng) begin
      b_side = '{res_cost: '0, res_hits: '0, use_quot: 1'b0, upd: 1'b0};
    end else if (!b_upd) begin
      b_side = '{res_cost: b_cost, res_hits: b_hits, use_quot: 1'b0, upd: 1'b0};
    end else if (b_m0) begin
      b_side = '{res_cost: '0, res_hits: b_nh, use_quot: 1'b1, upd: 1'b1};
    end else begin
      b_side = '{res_cost: b_l2_sat, res_hits: b_nh, use_quot: 1'b0, upd: 1'b1};
    end
  end

  logic              d_vld;
  logic [NUM_W-1:0]  d_quot;
  div_side_t         d_side;
  logic [CELL_W-1:0] d_addr;

  cvu_div_pipe #(
    .CELL_W (CELL_W)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_vld     (b_vld),
    .in_num     (b_num),
    .in_den     (b_nh),
    .in_side    (b_side),
    .in_addr    (b_addr),
    .probe_addr (e_addr),
    .probe_hit  (div_hit),
    .out_vld    (d_vld),
    .out_quot   (d_quot),
    .out_side   (d_side),
    .out_addr   (d_addr)
  );

  // write back as the result enters the output register
  logic [COST_W-1:0] d_cost;
  assign d_cost  = !d_side.use_quot ? d_side.res_cost :
                   (|d_quot[NUM_W-1:COST_W]) ? COST_MAX : d_quot[COST_W-1:0];
  assign wr_en   = adv && d_vld && d_side.upd;
  assign wr_addr = d_addr;
  assign wr_cost = d_cost;
  assign wr_hits = d_side.res_hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && d_vld) begin
      cell_cost   <= d_cost;
      cell_hits   <= d_side.res_hits;
      was_updated <= d_side.upd;
    end
  end

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("item accepted during memory clear");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !out_valid && !wr_en) else $error("pipeline active during memory clear");

  a_update_has_hits: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_updated |-> cell_hits != '0) else $error("updated cell with zero hits");

  a_no_same_cell_overlap: assert property (@(posedge clk) disable iff (rst)
    a_vld && b_vld |-> a_addr != b_addr) else $error("two transactions on one cell in flight");

  a_stall_holds_write: assert property (@(posedge clk) disable iff (rst)
    !adv |-> !wr_en) else $error("write-back during stall");

endmodule
`default_nettype wire
